FILE: hw/rtl/rgbmx_pkg.sv
// Shared types, codes and constants of the RGB LED matrix scan and PWM core.
`timescale 1ns / 1ps
package rgbmx_pkg;

  localparam int unsigned LinesDef   = 10;
  localparam int unsigned RowsDef    = 3;
  localparam int unsigned Colours    = 3;
  localparam int unsigned LevelW     = 4;
  localparam int unsigned PixW       = Colours * LevelW;
  localparam int unsigned InLevelW   = 8;
  localparam int unsigned TimerW     = 8;
  localparam int unsigned LineW      = 4;
  localparam int unsigned RowW       = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 4;

  localparam logic [LevelW-1:0] MaxBrightRst  = 4'd7;
  localparam logic [LevelW-1:0] MaxGlobalRst  = 4'd5;
  localparam logic [LevelW-1:0] GlobalRst     = 4'd1;

  localparam logic [CfgIdxW-1:0] RegMaxBright  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxGlobal  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGlobal     = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                tick;
    logic                clear;
    logic [LevelW-1:0]   gain;
    logic [TimerW-1:0]   total;
  } ch_ctrl_t;

endpackage

FILE: hw/rtl/rgbmx_if.sv
// Valid/ready channel interfaces for the command and result beats.
`timescale 1ns / 1ps
interface rgbmx_cmd_if
  import rgbmx_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [LineW-1:0]    line;
  logic [RowW-1:0]     row;
  logic [InLevelW-1:0] red_level;
  logic [InLevelW-1:0] green_level;
  logic [InLevelW-1:0] blue_level;

  modport source (output valid, cmd, line, row, red_level, green_level, blue_level,
                  input ready);
  modport sink (input valid, cmd, line, row, red_level, green_level, blue_level,
                output ready);
endinterface

interface rgbmx_res_if
  import rgbmx_pkg::*;
#(
  parameter int unsigned LINES = LinesDef,
  parameter int unsigned ROWS  = RowsDef
) ();
  logic                      valid;
  logic                      ready;
  logic [LINES-1:0]          line_select;
  logic [ROWS*Colours-1:0]   lit_mask;
  logic [LevelW-1:0]         read_red;
  logic [LevelW-1:0]         read_green;
  logic [LevelW-1:0]         read_blue;

  modport source (output valid, line_select, lit_mask, read_red, read_green, read_blue,
                  input ready);
  modport sink (input valid, line_select, lit_mask, read_red, read_green, read_blue,
                output ready);
endinterface

FILE: hw/rtl/rgb_led_matrix_scan_pwm_core.sv
// Top level of the RGB LED matrix scan and PWM core.
// The block takes command beats on in_i and returns exactly one result beat on out_o for
// each of them, in order. A tick command advances the scan counter and, past the period
// max_bright * max_global_bright, moves to the next line and restarts every channel off.
// A write command stores a pixel's colour levels, each clamped to max_bright, and a read
// command returns a stored pixel. Every result carries the one-hot line select and the
// lit mask after the command.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write them only while the block is idle, which the block itself does not enforce.
// At the accepting edge the pixel memory is read and the command is registered in the memory
// read stage; the channel update then loads the output register, which offers the result
// beat. One beat is taken every cycle while no stall holds the output; the rate is set by
// the single read port of the pixel memory, which serves one tick or one read per cycle.
// When the receiver stalls, the output register holds its beat and one more beat waits
// in the memory read stage; only then does in_i drop ready.
// After reset the pixel store reads as zero, line 0 is selected, all channels are off
// and the registers hold 7, 5 and 1.
`timescale 1ns / 1ps
module rgb_led_matrix_scan_pwm_core
  import rgbmx_pkg::*;
#(
  parameter int unsigned LINES = LinesDef,
  parameter int unsigned ROWS  = RowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rgbmx_cmd_if.sink           in_i,
  rgbmx_res_if.source         out_o
);

  localparam int unsigned LW = $clog2(LINES);
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CH = ROWS * Colours;

  logic [LevelW-1:0] max_bright_q, max_global_q, global_q;
  logic [TimerW-1:0] total;
  logic [LevelW-1:0] gain_lo, gain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bright_q <= MaxBrightRst;
      max_global_q <= MaxGlobalRst;
      global_q     <= GlobalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxBright: max_bright_q <= cfg_data_i;
        RegMaxGlobal: max_global_q <= cfg_data_i;
        RegGlobal:    global_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign total   = TimerW'(max_bright_q) * TimerW'(max_global_q);
  assign gain_lo = (global_q == '0) ? LevelW'(1) : global_q;
  assign gain    = (gain_lo > max_global_q) ? max_global_q : gain_lo;

  logic in_acc, s1_adv;
  logic s1_valid_q, out_valid_q;
  cmd_e cmd;
  logic pix_ok;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.cmd);
  assign pix_ok     = (5'(in_i.line) < 5'(LINES)) && (4'(in_i.row) < 4'(ROWS));

  logic [TimerW-1:0] scan_q, scan_d, scan_inc;
  logic [LW-1:0]     line_q, line_d, line_nxt;
  logic              wrap;

  assign scan_inc = scan_q + TimerW'(1);
  assign wrap     = scan_inc > total;
  assign line_nxt = (line_q == LW'(LINES - 1)) ? '0 : line_q + LW'(1);

  always_comb begin
    scan_d = scan_q;
    line_d = line_q;
    if (in_acc && cmd == CMD_TICK) begin
      scan_d = wrap ? '0 : scan_inc;
      line_d = wrap ? line_nxt : line_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      line_q <= '0;
    end else begin
      scan_q <= scan_d;
      line_q <= line_d;
    end
  end

  logic [InLevelW-1:0] max_ext;
  logic [PixW-1:0]     wr_data;
  logic                mem_we, mem_re;
  logic [LW-1:0]       rd_line;
  logic [ROWS-1:0][PixW-1:0] rd_data;

  assign max_ext = InLevelW'(max_bright_q);
  assign wr_data = {
    (in_i.blue_level  > max_ext) ? max_bright_q : in_i.blue_level[LevelW-1:0],
    (in_i.green_level > max_ext) ? max_bright_q : in_i.green_level[LevelW-1:0],
    (in_i.red_level   > max_ext) ? max_bright_q : in_i.red_level[LevelW-1:0]
  };
  assign mem_we  = in_acc && cmd == CMD_WRITE && pix_ok;
  assign mem_re  = in_acc && (cmd == CMD_TICK || (cmd == CMD_READ && pix_ok));
  assign rd_line = (cmd == CMD_TICK) ? line_d : in_i.line[LW-1:0];

  rgbmx_pixel_store #(
    .LINES(LINES),
    .ROWS (ROWS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (mem_we),
    .wr_line_i(in_i.line[LW-1:0]),
    .wr_row_i (RW'(in_i.row)),
    .wr_data_i(wr_data),
    .re_i     (mem_re),
    .rd_line_i(rd_line),
    .rd_data_o(rd_data)
  );

  logic            s1_tick_q, s1_clear_q, s1_rd_q;
  logic [RowW-1:0] s1_row_q;
  logic [LW-1:0]   s1_line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_tick_q  <= 1'b0;
      s1_clear_q <= 1'b0;
      s1_rd_q    <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
      s1_tick_q  <= in_acc && cmd == CMD_TICK;
      s1_clear_q <= in_acc && cmd == CMD_TICK && wrap;
      s1_rd_q    <= in_acc && cmd == CMD_READ && pix_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_row_q  <= in_i.row;
      s1_line_q <= line_d;
    end
  end

  ch_ctrl_t      ch_ctrl;
  logic [CH-1:0] lit_d;

  assign ch_ctrl = '{tick: s1_tick_q, clear: s1_clear_q, gain: gain, total: total};

  rgbmx_channels #(
    .ROWS(ROWS)
  ) u_channels (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .ctrl_i  (ch_ctrl),
    .levels_i(rd_data),
    .lit_d_o (lit_d)
  );

  logic [PixW-1:0] rd_pix;

  always_comb begin
    rd_pix = '0;
    for (int unsigned r = 0; r < ROWS; r++) begin
      if (s1_rd_q && 4'(s1_row_q) == 4'(r)) begin
        rd_pix = rd_data[r];
      end
    end
  end

  logic [LINES-1:0]  out_sel_q;
  logic [CH-1:0]     out_lit_q;
  logic [PixW-1:0]   out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sel_q <= LINES'(1) << s1_line_q;
      out_lit_q <= lit_d;
      out_pix_q <= rd_pix;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.line_select = out_sel_q;
  assign out_o.lit_mask    = out_lit_q;
  assign out_o.read_red    = out_pix_q[0 * LevelW +: LevelW];
  assign out_o.read_green  = out_pix_q[1 * LevelW +: LevelW];
  assign out_o.read_blue   = out_pix_q[2 * LevelW +: LevelW];

endmodule

FILE: hw/rtl/rgbmx_pixel_store.sv
// Pixel colour memory, one word per line, with per-pixel valid bits for reset.
`timescale 1ns / 1ps
module rgbmx_pixel_store
  import rgbmx_pkg::*;
#(
  parameter int unsigned LINES = LinesDef,
  parameter int unsigned ROWS  = RowsDef,
  localparam int unsigned LW   = $clog2(LINES),
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [LW-1:0]                  wr_line_i,
  input  logic [RW-1:0]                  wr_row_i,
  input  logic [PixW-1:0]                wr_data_i,
  input  logic                           re_i,
  input  logic [LW-1:0]                  rd_line_i,
  output logic [ROWS-1:0][PixW-1:0]      rd_data_o
);

  logic [ROWS-1:0][PixW-1:0] mem_q [LINES];
  logic [ROWS-1:0]           vld_q [LINES];
  logic [ROWS-1:0][PixW-1:0] rdata_q;
  logic [ROWS-1:0]           rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_line_i][wr_row_i] <= wr_data_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[rd_line_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned l = 0; l < LINES; l++) begin
        vld_q[l] <= '0;
      end
      rvld_q <= '0;
    end else begin
      if (we_i) begin
        vld_q[wr_line_i][wr_row_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[rd_line_i];
      end
    end
  end

  always_comb begin
    for (int unsigned r = 0; r < ROWS; r++) begin
      rd_data_o[r] = rvld_q[r] ? rdata_q[r] : '0;
    end
  end

endmodule

FILE: hw/rtl/rgbmx_channels.sv
// PWM channel machines of the active line, one lane per LED colour of each row.
`timescale 1ns / 1ps
module rgbmx_channels
  import rgbmx_pkg::*;
#(
  parameter int unsigned ROWS = RowsDef,
  localparam int unsigned CH  = ROWS * Colours
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  ch_ctrl_t                  ctrl_i,
  input  logic [ROWS-1:0][PixW-1:0] levels_i,
  output logic [CH-1:0]             lit_d_o
);

  logic [TimerW-1:0] tmr_q [CH];
  logic [TimerW-1:0] tmr_d [CH];
  logic [CH-1:0]     lit_q;
  logic [CH-1:0]     lit_d;

  for (genvar c = 0; c < CH; c++) begin : g_lane
    logic [LevelW-1:0] lvl;
    logic [TimerW-1:0] cur;
    logic [TimerW-1:0] cur_c;
    logic [TimerW-1:0] off_len;
    logic [TimerW-1:0] tmr_base;
    logic [TimerW-1:0] tmr_inc;
    logic              lit_base;
    logic [TimerW-1:0] tmr_nx;
    logic              lit_nx;

    assign lvl     = levels_i[c / Colours][(c % Colours) * LevelW +: LevelW];
    assign cur     = TimerW'(ctrl_i.gain) * TimerW'(lvl);
    assign cur_c   = (cur > ctrl_i.total) ? ctrl_i.total : cur;
    assign off_len = ctrl_i.total - cur_c;

    always_comb begin
      tmr_base = ctrl_i.clear ? '0 : tmr_q[c];
      lit_base = ctrl_i.clear ? 1'b0 : lit_q[c];
      tmr_inc  = tmr_base + TimerW'(1);
      tmr_nx   = tmr_q[c];
      lit_nx   = lit_q[c];
      if (ctrl_i.tick) begin
        tmr_nx = tmr_inc;
        lit_nx = lit_base;
        if (!lit_base) begin
          if (tmr_inc >= off_len) begin
            tmr_nx = '0;
            lit_nx = (cur_c != '0);
          end
        end else begin
          if (tmr_inc >= cur_c) begin
            tmr_nx = '0;
            lit_nx = (off_len == '0);
          end
        end
      end
    end

    assign tmr_d[c] = tmr_nx;
    assign lit_d[c] = lit_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q <= '0;
      for (int unsigned c = 0; c < CH; c++) begin
        tmr_q[c] <= '0;
      end
    end else if (step_i) begin
      lit_q <= lit_d;
      for (int unsigned c = 0; c < CH; c++) begin
        tmr_q[c] <= tmr_d[c];
      end
    end
  end

  assign lit_d_o = lit_d;

endmodule

FILE: hw/rtl/rgbmx_checker.sv
// Port-level checks of the matrix scan core, bound to its top level.
`timescale 1ns / 1ps
module rgbmx_checker
  import rgbmx_pkg::*;
#(
  parameter int unsigned LINES = LinesDef,
  parameter int unsigned ROWS  = RowsDef
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [LINES-1:0]          line_select_i,
  input logic [ROWS*Colours-1:0]   lit_mask_i
);

  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot(line_select_i))
    else $error("line select of a result beat is not one-hot");

  a_no_out_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result beat shown during reset");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input not ready while the receiver takes beats");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(line_select_i)
      && $stable(lit_mask_i))
    else $error("stalled result beat changed");

  a_idle_in_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !out_valid_i |=> in_ready_i)
    else $error("empty pipeline refuses input");

endmodule

bind rgb_led_matrix_scan_pwm_core rgbmx_checker #(
  .LINES(LINES),
  .ROWS (ROWS)
) u_rgbmx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .line_select_i(out_o.line_select),
  .lit_mask_i   (out_o.lit_mask)
);

FILE: bench/tb_top.sv
// Self-checking bench for the RGB LED matrix scan and PWM core with a predictor of every result beat.
`timescale 1ns / 1ps
module tb_top;
  import rgbmx_pkg::*;

  localparam int unsigned Channels = RowsDef * Colours;
  localparam int unsigned CycleLimit = 100000;
  localparam logic [CfgIdxW-1:0] RegNone = 2'd3;

  typedef struct packed {
    cmd_e                cmd;
    logic [LineW-1:0]    line;
    logic [RowW-1:0]     row;
    logic [InLevelW-1:0] red;
    logic [InLevelW-1:0] green;
    logic [InLevelW-1:0] blue;
  } cmd_beat_t;

  typedef struct packed {
    logic [LinesDef-1:0] line_select;
    logic [Channels-1:0] lit_mask;
    logic [LevelW-1:0]   red;
    logic [LevelW-1:0]   green;
    logic [LevelW-1:0]   blue;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  rgbmx_cmd_if cmd_if ();
  rgbmx_res_if res_if ();

  rgb_led_matrix_scan_pwm_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  always #5 clk = ~clk;

  // Predicted block state.
  logic [LevelW-1:0] px_lvl [LinesDef*RowsDef][Colours];
  logic [LineW-1:0]  line_now;
  logic [TimerW-1:0] scan_cnt;
  logic [Channels-1:0] lit_now;
  logic [TimerW-1:0] ch_timer [Channels];
  logic [LevelW-1:0] m_max_bright;
  logic [LevelW-1:0] m_max_global;
  logic [LevelW-1:0] m_global;

  cmd_beat_t cmd_backlog[$];
  frame_t    frames_due[$];
  cmd_beat_t live_beat;
  bit        beat_live = 1'b0;
  int        idle_send_pct = 0;
  int        stall_recv_pct = 0;
  int        mismatches = 0;
  int        cycles = 0;

  function automatic frame_t advance_matrix(cmd_beat_t b);
    frame_t f;
    int total;
    int g;
    int lvl;
    int cur;
    int idx;
    bit hit;
    logic [InLevelW-1:0] in_lvl [Colours];
    f = '0;
    in_lvl[0] = b.red;
    in_lvl[1] = b.green;
    in_lvl[2] = b.blue;
    hit = (b.line < LinesDef) && (b.row < RowsDef);
    idx = int'(b.line) * RowsDef + int'(b.row);
    case (b.cmd)
      CMD_TICK: begin
        total = int'(m_max_bright) * int'(m_max_global);
        scan_cnt = scan_cnt + 8'd1;
        if (int'(scan_cnt) > total) begin
          scan_cnt = '0;
          line_now = (line_now >= LinesDef - 1) ? '0 : line_now + 4'd1;
          lit_now = '0;
          foreach (ch_timer[c]) ch_timer[c] = '0;
        end
        g = int'(m_global);
        if (g < 1) g = 1;
        if (g > int'(m_max_global)) g = int'(m_max_global);
        for (int c = 0; c < Channels; c++) begin
          lvl = int'(px_lvl[int'(line_now) * RowsDef + c / Colours][c % Colours]);
          cur = g * lvl;
          if (cur > total) cur = total;
          ch_timer[c] = ch_timer[c] + 8'd1;
          if (!lit_now[c]) begin
            if (int'(ch_timer[c]) >= total - cur) begin
              ch_timer[c] = '0;
              if (cur >= 1) lit_now[c] = 1'b1;
            end
          end else if (int'(ch_timer[c]) >= cur) begin
            ch_timer[c] = '0;
            if (total - cur >= 1) lit_now[c] = 1'b0;
          end
        end
      end
      CMD_WRITE: begin
        if (hit) begin
          for (int k = 0; k < Colours; k++) begin
            px_lvl[idx][k] = (in_lvl[k] > m_max_bright) ? m_max_bright
                                                         : in_lvl[k][LevelW-1:0];
          end
        end
      end
      CMD_READ: begin
        if (hit) begin
          f.red = px_lvl[idx][0];
          f.green = px_lvl[idx][1];
          f.blue = px_lvl[idx][2];
        end
      end
      default: ;
    endcase
    f.line_select[line_now] = 1'b1;
    f.lit_mask = lit_now;
    return f;
  endfunction

  function automatic cmd_beat_t mk_beat(cmd_e c, int ln, int rw, int r, int g, int b);
    cmd_beat_t beat;
    beat.cmd = c;
    beat.line = ln[LineW-1:0];
    beat.row = rw[RowW-1:0];
    beat.red = r[InLevelW-1:0];
    beat.green = g[InLevelW-1:0];
    beat.blue = b[InLevelW-1:0];
    return beat;
  endfunction

  function automatic int random_level();
    return ($urandom_range(1) == 0) ? $urandom_range(17) : $urandom_range(255);
  endfunction

  function automatic cmd_beat_t random_beat();
    int pick;
    cmd_e c;
    pick = $urandom_range(99);
    if (pick < 55) c = CMD_TICK;
    else if (pick < 75) c = CMD_WRITE;
    else if (pick < 92) c = CMD_READ;
    else c = CMD_NOP;
    return mk_beat(c,
                   ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(9),
                   ($urandom_range(7) == 0) ? $urandom_range(3) : $urandom_range(2),
                   random_level(), random_level(), random_level());
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      RegMaxBright: m_max_bright = data;
      RegMaxGlobal: m_max_global = data;
      RegGlobal:    m_global = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || beat_live || frames_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [LevelW-1:0] mb, input logic [LevelW-1:0] mgb,
                           input logic [LevelW-1:0] gb, input int send_pct,
                           input int recv_pct, input int n_items, input int hold_at);
    write_reg(RegMaxBright, mb);
    write_reg(RegMaxGlobal, mgb);
    write_reg(RegGlobal, gb);
    repeat (2) @(posedge clk);
    @(negedge clk);
    idle_send_pct = send_pct;
    stall_recv_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) wait_drained();
      cmd_backlog.push_back(random_beat());
    end
    wait_drained();
  endtask

  // Command driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        frames_due.push_back(advance_matrix(live_beat));
        beat_live = 1'b0;
      end
      if (!beat_live) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_send_pct) begin
          live_beat = cmd_backlog.pop_front();
          beat_live = 1'b1;
          cmd_if.valid <= 1'b1;
          cmd_if.cmd <= live_beat.cmd;
          cmd_if.line <= live_beat.line;
          cmd_if.row <= live_beat.row;
          cmd_if.red_level <= live_beat.red;
          cmd_if.green_level <= live_beat.green;
          cmd_if.blue_level <= live_beat.blue;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.line_select = res_if.line_select;
        got.lit_mask = res_if.lit_mask;
        got.red = res_if.read_red;
        got.green = res_if.read_green;
        got.blue = res_if.read_blue;
        if (frames_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: %p", got);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (got.line_select !== want.line_select || got.lit_mask !== want.lit_mask ||
              got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          begin
            if (mismatches < 10) begin
              $display("result mismatch at cycle %0d:", cycles);
              $display("  expected line_select=%b lit_mask=%b rgb=%0d/%0d/%0d",
                       want.line_select, want.lit_mask, want.red, want.green, want.blue);
              $display("  actual   line_select=%b lit_mask=%b rgb=%0d/%0d/%0d",
                       got.line_select, got.lit_mask, got.red, got.green, got.blue);
            end
            mismatches++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= stall_recv_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.cmd = CMD_NOP;
    cmd_if.line = '0;
    cmd_if.row = '0;
    cmd_if.red_level = '0;
    cmd_if.green_level = '0;
    cmd_if.blue_level = '0;
    res_if.ready = 1'b0;
    px_lvl = '{default: '0};
    ch_timer = '{default: '0};
    line_now = '0;
    scan_cnt = '0;
    lit_now = '0;
    m_max_bright = MaxBrightRst;
    m_max_global = MaxGlobalRst;
    m_global = GlobalRst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);

    // Directed beats under the reset settings.
    cmd_backlog.push_back(mk_beat(CMD_READ, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 0, 0, 255, 0, 7));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 0, 1, 8, 6, 1));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 0, 2, 0, 255, 128));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 9, 2, 1, 2, 3));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 10, 0, 5, 5, 5));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 15, 3, 255, 255, 255));
    cmd_backlog.push_back(mk_beat(CMD_WRITE, 0, 3, 3, 3, 3));
    cmd_backlog.push_back(mk_beat(CMD_READ, 9, 2, 0, 0, 0));
    cmd_backlog.push_back(mk_beat(CMD_READ, 15, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_beat(CMD_READ, 0, 3, 0, 0, 0));
    cmd_backlog.push_back(mk_beat(CMD_NOP, 5, 1, 170, 85, 255));
    cmd_backlog.push_back(mk_beat(CMD_READ, 0, 0, 0, 0, 0));
    for (int i = 0; i < 12; i++) cmd_backlog.push_back(mk_beat(CMD_TICK, 0, 0, 0, 0, 0));
    for (int i = 0; i < 80; i++) cmd_backlog.push_back(random_beat());
    wait_drained();

    run_phase(4'd15, 4'd15, 4'd15, 53, 0, 70, -1);
    run_phase(4'd3, 4'd2, 4'd15, 0, 53, 70, 35);
    run_phase(4'd0, 4'd3, 4'd0, 20, 20, 50, -1);
    write_reg(RegNone, 4'hF);
    run_phase(4'd1, 4'd1, 4'd1, 0, 0, 60, -1);
    run_phase(4'd4, 4'd0, 4'd9, 53, 0, 40, -1);
    run_phase(4'd5, 4'd3, 4'd2, 0, 53, 55, -1);

    repeat (8) @(posedge clk);
    if (frames_due.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
